### hw/rtl/tdcsu_pkg.sv
// Shared types, constants and codes for the TDC/scaler subevent unpacker.
// No dependencies; used by the top level, the queue, front and back modules and the testbench.
package tdcsu_pkg;

    localparam int ScalerCountDefault = 32;
    localparam int QueueDepthDefault  = 4;

    // Scaler rows: 8 rows of 4 scalers, one RAM bank per column.
    localparam int RowCount   = 8;
    localparam int RowW       = 3;
    localparam int BankCount  = 4;
    localparam int StoreDepth = RowCount * BankCount;
    localparam int StoreIdxW  = 5;

    localparam int CfgAddrW = 3;

    localparam logic [3:0]  CalTypeNibble = 4'h9;
    localparam logic [31:0] CalHeaderWord = 32'h0800_0000;
    localparam logic [23:0] TrailerMark   = 24'h08_0000;
    localparam logic [11:0] AdcOverrange  = 12'hfff;
    localparam logic [1:0]  TrigChanHigh  = 2'b11;   // channels 24..31
    localparam logic [8:0]  TrigCalBits   = 9'h100;

    localparam logic [7:0] TrigCrateReset = 8'd2;
    localparam logic [4:0] TrigSlotReset  = 5'd11;

    typedef enum logic {
        REG_TRIG_CRATE = 1'b0,
        REG_TRIG_SLOT  = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        KIND_HIT = 2'd0,
        KIND_ROW = 2'd1,
        KIND_SUM = 2'd2
    } kind_t;

    // Classified word as it travels from the front to the back.
    typedef struct packed {
        logic [31:0] word;
        logic        last;
        logic        cal_first;
        logic        cal_header;
        logic        trailer;
        logic        top_set;
        logic        zero;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  hit_crate;
        logic [4:0]  hit_slot;
        logic [4:0]  hit_channel;
        logic [11:0] hit_value;
        logic [2:0]  row_index;
        logic [23:0] scaler_a;
        logic [23:0] scaler_b;
        logic [23:0] scaler_c;
        logic [23:0] scaler_d;
        logic [8:0]  trigger_bits;
        logic        final_result;
    } res_t;

endpackage

### hw/rtl/tdcsu_if.sv
// Word channels of the unpacker: raw input words and result words.
// Valid/ready handshake; no dependencies.
interface tdcsu_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic        last_word;

    modport source (output valid, data_word, last_word, input ready);
    modport sink   (input valid, data_word, last_word, output ready);
endinterface

interface tdcsu_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [7:0]  hit_crate;
    logic [4:0]  hit_slot;
    logic [4:0]  hit_channel;
    logic [11:0] hit_value;
    logic [2:0]  row_index;
    logic [23:0] scaler_a;
    logic [23:0] scaler_b;
    logic [23:0] scaler_c;
    logic [23:0] scaler_d;
    logic [8:0]  trigger_bits;
    logic        final_result;

    modport source (output valid, result_kind, hit_crate, hit_slot, hit_channel, hit_value,
                    row_index, scaler_a, scaler_b, scaler_c, scaler_d, trigger_bits,
                    final_result, input ready);
    modport sink   (input valid, result_kind, hit_crate, hit_slot, hit_channel, hit_value,
                    row_index, scaler_a, scaler_b, scaler_c, scaler_d, trigger_bits,
                    final_result, output ready);
endinterface

### hw/rtl/tdc_scaler_subevent_unpacker.sv
// TDC/scaler subevent unpacker, top level: APB registers, front, queue, back.
// An input word is registered in the queue, and its result word in the result register.
// Throughput: 1 word per cycle while the result side keeps up; after the last word of a
// calibration subevent the back sends each scaler row (a registered RAM read, then the
// row output) and then the summary, after any other last word only the summary.
// Reset (rst_n, async low): parser awaits a first word, queue empty, trigger crate 2, slot 11.
module tdc_scaler_subevent_unpacker #(
    parameter int SCALER_COUNT = tdcsu_pkg::ScalerCountDefault,
    parameter int QUEUE_DEPTH  = tdcsu_pkg::QueueDepthDefault
) (
    input  logic                          clk,
    input  logic                          rst_n,
    tdcsu_in_if.sink                      word_in,
    tdcsu_out_if.source                   result_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tdcsu_pkg::CfgAddrW-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    // Configuration registers. Register i sits at byte address 4*i, so
    // paddr[2] selects it; written in the APB access phase.
    logic [7:0]          trig_crate_reg;
    logic [4:0]          trig_slot_reg;
    logic                cfg_wr;
    tdcsu_pkg::reg_idx_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = tdcsu_pkg::reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_crate_reg <= tdcsu_pkg::TrigCrateReset;
            trig_slot_reg  <= tdcsu_pkg::TrigSlotReset;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                tdcsu_pkg::REG_TRIG_CRATE: trig_crate_reg <= pwdata[7:0];
                tdcsu_pkg::REG_TRIG_SLOT:  trig_slot_reg  <= pwdata[4:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            tdcsu_pkg::REG_TRIG_CRATE: prdata = {24'd0, trig_crate_reg};
            tdcsu_pkg::REG_TRIG_SLOT:  prdata = {27'd0, trig_slot_reg};
            default:                   prdata = '0;
        endcase
    end

    // Front classifies each word; the queue lets the front keep taking words
    // while the back is busy draining rows or waiting on the result side.
    tdcsu_pkg::cmd_t front_cmd;
    tdcsu_pkg::cmd_t back_cmd;
    logic            front_push;
    logic            queue_full;
    logic            queue_not_empty;
    logic            back_pop;

    tdcsu_front u_front (
        .word_in    (word_in),
        .queue_full (queue_full),
        .push       (front_push),
        .cmd        (front_cmd)
    );

    tdcsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_push),
        .push_data (front_cmd),
        .full      (queue_full),
        .pop       (back_pop),
        .pop_data  (back_cmd),
        .not_empty (queue_not_empty)
    );

    // Back runs the subevent parser, keeps the scalers and owns the result
    // register, which decouples it from result-side stalls.
    tdcsu_back #(
        .SCALER_COUNT (SCALER_COUNT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (back_cmd),
        .cmd_valid  (queue_not_empty),
        .cmd_pop    (back_pop),
        .trig_crate (trig_crate_reg),
        .trig_slot  (trig_slot_reg),
        .result_out (result_out)
    );

endmodule

### hw/rtl/tdcsu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tdcsu_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/tdcsu_queue.sv
// Short FIFO of classified words between the front and the back.
// Depends on tdcsu_pkg.
module tdcsu_queue #(
    parameter int DEPTH = tdcsu_pkg::QueueDepthDefault
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  tdcsu_pkg::cmd_t    push_data,
    output logic               full,
    input  logic               pop,
    output tdcsu_pkg::cmd_t    pop_data,
    output logic               not_empty
);

    localparam int AW = $clog2(DEPTH);

    tdcsu_pkg::cmd_t mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [AW:0]     count_reg, count_next;

    assign full      = (count_reg == (AW+1)'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hw/rtl/tdcsu_front.sv
// Front end: accepts raw words and tags them with the patterns the parser needs.
// Depends on tdcsu_pkg and tdcsu_in_if.
module tdcsu_front (
    tdcsu_in_if.sink        word_in,
    input  logic            queue_full,
    output logic            push,
    output tdcsu_pkg::cmd_t cmd
);

    logic [31:0] w;

    assign w             = word_in.data_word;
    assign word_in.ready = !queue_full;
    assign push          = word_in.valid && !queue_full;

    always_comb
    begin
        cmd.word       = w;
        cmd.last       = word_in.last_word;
        cmd.cal_first  = (w[11:8] == tdcsu_pkg::CalTypeNibble);
        cmd.cal_header = (w == tdcsu_pkg::CalHeaderWord);
        cmd.trailer    = (w[31:8] == tdcsu_pkg::TrailerMark);
        cmd.top_set    = |w[31:24];
        cmd.zero       = (w == '0);
    end

endmodule

### hw/rtl/tdcsu_back.sv
// Back end: subevent parser, scaler store in four RAM banks, result sequencer.
// Depends on tdcsu_pkg, tdcsu_out_if and tdcsu_ram.
module tdcsu_back #(
    parameter int SCALER_COUNT = tdcsu_pkg::ScalerCountDefault
) (
    input  logic            clk,
    input  logic            rst_n,
    input  tdcsu_pkg::cmd_t cmd,
    input  logic            cmd_valid,
    output logic            cmd_pop,
    input  logic [7:0]      trig_crate,
    input  logic [4:0]      trig_slot,
    tdcsu_out_if.source     result_out
);

    localparam int CntW = $clog2(SCALER_COUNT + 1);

    typedef enum logic [6:0] {
        PH_FIRST    = 7'b000_0001,
        PH_CAL_HDR  = 7'b000_0010,
        PH_CAL_DATA = 7'b000_0100,
        PH_CAL_DONE = 7'b000_1000,
        PH_HEADER   = 7'b001_0000,
        PH_CHANNELS = 7'b010_0000,
        PH_DONE     = 7'b100_0000
    } phase_t;

    typedef enum logic [3:0] {
        SQ_WORD    = 4'b0001,
        SQ_ROW_RD  = 4'b0010,
        SQ_ROW_OUT = 4'b0100,
        SQ_SUM     = 4'b1000
    } seq_t;

    phase_t                      phase_reg, phase_next;
    seq_t                        seq_reg, seq_next;
    logic [7:0]                  chan_left_reg, chan_left_next;
    logic [7:0]                  crate_reg, crate_next;
    logic [4:0]                  slot_reg, slot_next;
    logic [CntW-1:0]             count_reg, count_next;
    logic                        cleared_reg, cleared_next;
    logic [8:0]                  trig_reg, trig_next;
    logic                        is_cal_reg, is_cal_next;
    logic [tdcsu_pkg::RowW-1:0]  row_reg, row_next;
    logic                        res_valid_reg, res_valid_next;
    tdcsu_pkg::res_t             res_reg, res_next;

    logic                                   out_free;
    logic                                   do_scaler;
    logic                                   store_we;
    logic [23:0]                            store_wdata;
    logic [tdcsu_pkg::StoreIdxW-1:0]        wr_idx;
    logic [23:0]                            bank_rdata [tdcsu_pkg::BankCount];
    logic [23:0]                            bank_val   [tdcsu_pkg::BankCount];
    logic [4:0]                             ch;
    logic [11:0]                            adc;

    assign out_free = !res_valid_reg || result_out.ready;
    assign wr_idx   = tdcsu_pkg::StoreIdxW'(count_reg);
    assign ch       = cmd.word[20:16];
    assign adc      = (cmd.word[11:0] == tdcsu_pkg::AdcOverrange) ? 12'd0 : cmd.word[11:0];

    // One bank per column of the row; bank b holds scalers 8b..8b+7.
    for (genvar b = 0; b < tdcsu_pkg::BankCount; b++)
    begin : g_bank
        logic [tdcsu_pkg::StoreIdxW-1:0] rd_idx;
        logic                            bank_we;

        assign bank_we = store_we
                         && (32'(count_reg) < 32'(tdcsu_pkg::StoreDepth))
                         && (wr_idx[tdcsu_pkg::StoreIdxW-1:tdcsu_pkg::RowW] == 2'(b));
        assign rd_idx  = {2'(b), row_reg};
        // Entries past the fill count, or after an overflow, read as zero.
        assign bank_val[b] = (!cleared_reg && (32'(rd_idx) < 32'(count_reg)))
                             ? bank_rdata[b] : 24'd0;

        tdcsu_ram #(
            .WIDTH (24),
            .DEPTH (tdcsu_pkg::RowCount)
        ) u_ram (
            .clk   (clk),
            .we    (bank_we),
            .waddr (wr_idx[tdcsu_pkg::RowW-1:0]),
            .wdata (store_wdata),
            .raddr (row_reg),
            .rdata (bank_rdata[b])
        );
    end

    always_comb
    begin
        phase_next     = phase_reg;
        seq_next       = seq_reg;
        chan_left_next = chan_left_reg;
        crate_next     = crate_reg;
        slot_next      = slot_reg;
        count_next     = count_reg;
        cleared_next   = cleared_reg;
        trig_next      = trig_reg;
        is_cal_next    = is_cal_reg;
        row_next       = row_reg;
        res_valid_next = res_valid_reg && !result_out.ready;
        res_next       = res_reg;
        cmd_pop        = 1'b0;
        do_scaler      = 1'b0;
        store_we       = 1'b0;
        store_wdata    = cmd.top_set ? 24'd0 : cmd.word[23:0];

        case (seq_reg)
            SQ_WORD:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_pop = 1'b1;
                    case (phase_reg)
                        PH_FIRST:
                        begin
                            if (cmd.cal_first)
                            begin
                                is_cal_next  = 1'b1;
                                trig_next    = tdcsu_pkg::TrigCalBits;
                                cleared_next = 1'b0;
                                count_next   = '0;
                                phase_next   = PH_CAL_HDR;
                            end
                            else
                            begin
                                is_cal_next = 1'b0;
                                trig_next   = '0;
                                phase_next  = PH_HEADER;
                            end
                        end
                        PH_CAL_HDR:
                        begin
                            phase_next = PH_CAL_DATA;
                            do_scaler  = !cmd.cal_header;
                        end
                        PH_CAL_DATA:
                        begin
                            do_scaler = 1'b1;
                        end
                        PH_HEADER:
                        begin
                            if (cmd.zero)
                            begin
                                phase_next = PH_DONE;
                            end
                            else
                            begin
                                slot_next      = cmd.word[31:27];
                                crate_next     = cmd.word[23:16];
                                chan_left_next = cmd.word[15:8];
                                phase_next     = (cmd.word[15:8] != '0) ? PH_CHANNELS
                                                                        : PH_HEADER;
                            end
                        end
                        PH_CHANNELS:
                        begin
                            res_valid_next           = 1'b1;
                            res_next                 = '0;
                            res_next.result_kind     = tdcsu_pkg::KIND_HIT;
                            res_next.hit_crate       = crate_reg;
                            res_next.hit_slot        = slot_reg;
                            res_next.hit_channel     = ch;
                            res_next.hit_value       = adc;
                            res_next.final_result    = !cmd.last;
                            if (crate_reg == trig_crate && slot_reg == trig_slot
                                && ch[4:3] == tdcsu_pkg::TrigChanHigh)
                            begin
                                trig_next = trig_reg | (9'd1 << ch[2:0]);
                            end
                            chan_left_next = chan_left_reg - 1'b1;
                            if (chan_left_reg == 8'd1)
                            begin
                                phase_next = PH_HEADER;
                            end
                        end
                        default:
                        begin
                        end
                    endcase

                    if (do_scaler)
                    begin
                        if (cmd.trailer)
                        begin
                            phase_next = PH_CAL_DONE;
                        end
                        else if (32'(count_reg) < 32'(SCALER_COUNT))
                        begin
                            store_we   = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                        else
                        begin
                            cleared_next = 1'b1;
                            phase_next   = PH_CAL_DONE;
                        end
                    end

                    if (cmd.last)
                    begin
                        row_next = '0;
                        seq_next = is_cal_next ? SQ_ROW_RD : SQ_SUM;
                    end
                end
            end
            SQ_ROW_RD:
            begin
                seq_next = SQ_ROW_OUT;
            end
            SQ_ROW_OUT:
            begin
                if (out_free)
                begin
                    res_valid_next       = 1'b1;
                    res_next             = '0;
                    res_next.result_kind = tdcsu_pkg::KIND_ROW;
                    res_next.row_index   = row_reg;
                    res_next.scaler_a    = bank_val[0];
                    res_next.scaler_b    = bank_val[1];
                    res_next.scaler_c    = bank_val[2];
                    res_next.scaler_d    = bank_val[3];
                    if (row_reg == tdcsu_pkg::RowW'(tdcsu_pkg::RowCount - 1))
                    begin
                        seq_next = SQ_SUM;
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                        seq_next = SQ_ROW_RD;
                    end
                end
            end
            SQ_SUM:
            begin
                if (out_free)
                begin
                    res_valid_next        = 1'b1;
                    res_next              = '0;
                    res_next.result_kind  = tdcsu_pkg::KIND_SUM;
                    res_next.trigger_bits = trig_reg;
                    res_next.final_result = 1'b1;
                    phase_next            = PH_FIRST;
                    chan_left_next        = '0;
                    trig_next             = '0;
                    is_cal_next           = 1'b0;
                    seq_next              = SQ_WORD;
                end
            end
            default:
            begin
                seq_next = SQ_WORD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FIRST;
            seq_reg       <= SQ_WORD;
            chan_left_reg <= '0;
            crate_reg     <= '0;
            slot_reg      <= '0;
            count_reg     <= '0;
            cleared_reg   <= 1'b0;
            trig_reg      <= '0;
            is_cal_reg    <= 1'b0;
            row_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            seq_reg       <= seq_next;
            chan_left_reg <= chan_left_next;
            crate_reg     <= crate_next;
            slot_reg      <= slot_next;
            count_reg     <= count_next;
            cleared_reg   <= cleared_next;
            trig_reg      <= trig_next;
            is_cal_reg    <= is_cal_next;
            row_reg       <= row_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign result_out.valid        = res_valid_reg;
    assign result_out.result_kind  = res_reg.result_kind;
    assign result_out.hit_crate    = res_reg.hit_crate;
    assign result_out.hit_slot     = res_reg.hit_slot;
    assign result_out.hit_channel  = res_reg.hit_channel;
    assign result_out.hit_value    = res_reg.hit_value;
    assign result_out.row_index    = res_reg.row_index;
    assign result_out.scaler_a     = res_reg.scaler_a;
    assign result_out.scaler_b     = res_reg.scaler_b;
    assign result_out.scaler_c     = res_reg.scaler_c;
    assign result_out.scaler_d     = res_reg.scaler_d;
    assign result_out.trigger_bits = res_reg.trigger_bits;
    assign result_out.final_result = res_reg.final_result;

endmodule

### dv/tb_tdc_scaler_subevent_unpacker.sv
// Testbench for the TDC/scaler subevent unpacker: directed stimulus table, then random
// subevents, every result word checked against a behavioral unpacker kept in this file.
// Depends on tdcsu_pkg, the tdcsu word interfaces and the RTL top level.
`timescale 1ns / 100ps

module tb_tdc_scaler_subevent_unpacker;
    import tdcsu_pkg::*;

    localparam int ScalerSlots    = ScalerCountDefault;
    localparam int CycleLimit     = 300000;
    localparam int SettleCycles   = 24;     // well past the result latency and row readout
    localparam int PhaseWords     = 27;     // random words per register setting
    localparam int PhaseCount     = 4;
    localparam int MaxGap         = 16;
    localparam int LongHoldAfter  = 60;     // result count at which the sink stalls hard
    localparam int LongHoldCycles = 250;

    // Parser position of the behavioral unpacker
    typedef enum logic [2:0] {
        PH_AWAIT_FIRST,
        PH_CAL_HEADER,
        PH_CAL_SCALERS,
        PH_CAL_CLOSED,
        PH_DATA_HEADER,
        PH_DATA_CHANNELS,
        PH_DATA_CLOSED
    } parse_phase_t;

    // One directed word; typed rows carry the summary bits read straight off the format
    typedef struct packed {
        logic [31:0] word;
        logic        last;
        logic        typed;
        logic [8:0]  sum_bits;
    } stim_row_t;

    localparam int DirectedCount = 25;
    // Register values are at reset here: trigger crate 2, slot 11.
    localparam stim_row_t DirectedRows [DirectedCount] = '{
        // one-word data subevent right after reset: summary only, no bits
        '{32'h0000_0000, 1'b1, 1'b1, 9'h000},
        // data subevent: header slot 11 / crate 2 / 3 channels
        '{32'h0000_0100, 1'b0, 1'b0, 9'h000},
        '{32'h5802_0300, 1'b0, 1'b0, 9'h000},
        '{32'h0018_0fff, 1'b0, 1'b0, 9'h000},   // ch 24, ADC overrange reads as 0
        '{32'hffff_fffe, 1'b0, 1'b0, 9'h000},   // ch 31, ADC max, junk in ignored bits
        '{32'h0000_0000, 1'b0, 1'b0, 9'h000},   // zero channel word is still a hit
        '{32'h08ff_0000, 1'b0, 1'b0, 9'h000},   // header with zero channel count
        '{32'h0000_0000, 1'b0, 1'b0, 9'h000},   // zero header closes the data
        '{32'h1234_5678, 1'b1, 1'b1, 9'h081},   // ignored word; trigger bits 0 and 7
        // calibration subevent with header, odd scalers and trailer
        '{32'h0000_0900, 1'b0, 1'b0, 9'h000},
        '{32'h0800_0000, 1'b0, 1'b0, 9'h000},
        '{32'h00ff_ffff, 1'b0, 1'b0, 9'h000},   // largest scaler
        '{32'h0100_0000, 1'b0, 1'b0, 9'h000},   // top byte set: stored as zero
        '{32'h0000_0001, 1'b0, 1'b0, 9'h000},
        '{32'h0800_0012, 1'b0, 1'b0, 9'h000},   // trailer
        '{32'hdead_beef, 1'b1, 1'b0, 9'h000},   // ignored after trailer, then rows
        // calibration without header or trailer
        '{32'hffff_f9ff, 1'b0, 1'b0, 9'h000},
        '{32'h00ab_cdef, 1'b1, 1'b0, 9'h000},
        // calibration first word that is also the last word
        '{32'h0000_0900, 1'b1, 1'b0, 9'h000},
        // channel count beyond the end of the subevent
        '{32'h0000_0000, 1'b0, 1'b0, 9'h000},
        '{32'h5802_ff00, 1'b0, 1'b0, 9'h000},
        '{32'h0019_0123, 1'b0, 1'b0, 9'h000},
        '{32'h001a_0456, 1'b1, 1'b0, 9'h000},
        // trailer in the header position
        '{32'h0000_0900, 1'b0, 1'b0, 9'h000},
        '{32'h0800_00ff, 1'b1, 1'b0, 9'h000}
    };

    logic                clk = 1'b0;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [CfgAddrW-1:0] paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    tdcsu_in_if  word_if ();
    tdcsu_out_if res_if ();

    tdc_scaler_subevent_unpacker dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_in    (word_if),
        .result_out (res_if),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Behavioral unpacker state and its copy of the registers
    parse_phase_t parse_phase;
    logic [7:0]   chans_left;
    logic [7:0]   cur_crate;
    logic [4:0]   cur_slot;
    logic [6:0]   scaler_fill;
    logic [23:0]  scaler_mem [ScalerSlots];
    logic [8:0]   trig_accum;
    logic         cal_event;
    logic [7:0]   cfg_crate;
    logic [4:0]   cfg_slot;

    res_t          pending_results [$];   // expected result words, oldest first
    logic [31:0]   frame_words [$];       // words of the subevent being sent
    int unsigned   fail_count    = 0;
    int unsigned   results_taken = 0;
    int unsigned   cycle_count   = 0;
    bit            send_burst    = 1'b0;
    bit            take_burst    = 1'b0;

    function automatic void clear_scaler_mem();
        foreach (scaler_mem[i])
            scaler_mem[i] = '0;
    endfunction

    function automatic logic [23:0] scaler_at(int idx);
        return (idx < ScalerSlots) ? scaler_mem[idx] : 24'd0;
    endfunction

    // Trailer closes the block; a non-trailer word once the store is full wipes it
    task automatic store_scaler(input logic [31:0] w);
        if (w[31:8] == TrailerMark)
            parse_phase = PH_CAL_CLOSED;
        else if (scaler_fill < ScalerSlots)
        begin
            scaler_mem[scaler_fill] = (|w[31:24]) ? 24'd0 : w[23:0];
            scaler_fill++;
        end
        else
        begin
            clear_scaler_mem();
            parse_phase = PH_CAL_CLOSED;
        end
    endtask

    // Advance the unpacker by one word and queue the result words it yields
    task automatic unpack_word(input logic [31:0] w, input logic last);
        res_t       r;
        logic [4:0] ch;
        case (parse_phase)
            PH_AWAIT_FIRST:
            begin
                if (w[11:8] == CalTypeNibble)
                begin
                    cal_event   = 1'b1;
                    trig_accum  = TrigCalBits;
                    clear_scaler_mem();
                    scaler_fill = '0;
                    parse_phase = PH_CAL_HEADER;
                end
                else
                begin
                    cal_event   = 1'b0;
                    trig_accum  = '0;
                    parse_phase = PH_DATA_HEADER;
                end
            end
            PH_CAL_HEADER:
            begin
                parse_phase = PH_CAL_SCALERS;
                if (w != CalHeaderWord)
                    store_scaler(w);
            end
            PH_CAL_SCALERS:
                store_scaler(w);
            PH_DATA_HEADER:
            begin
                if (w == '0)
                    parse_phase = PH_DATA_CLOSED;
                else
                begin
                    cur_slot    = w[31:27];
                    cur_crate   = w[23:16];
                    chans_left  = w[15:8];
                    parse_phase = (chans_left != 0) ? PH_DATA_CHANNELS : PH_DATA_HEADER;
                end
            end
            PH_DATA_CHANNELS:
            begin
                ch = w[20:16];
                r = '0;
                r.result_kind  = KIND_HIT;
                r.hit_crate    = cur_crate;
                r.hit_slot     = cur_slot;
                r.hit_channel  = ch;
                r.hit_value    = (w[11:0] == AdcOverrange) ? 12'd0 : w[11:0];
                r.final_result = !last;
                pending_results.push_back(r);
                if (cur_crate == cfg_crate && cur_slot == cfg_slot && ch[4:3] == TrigChanHigh)
                    trig_accum[ch[2:0]] = 1'b1;
                chans_left = chans_left - 8'd1;
                if (chans_left == 0)
                    parse_phase = PH_DATA_HEADER;
            end
            default: ;
        endcase

        if (last)
        begin
            if (cal_event)
            begin
                for (int i = 0; i < RowCount; i++)
                begin
                    r = '0;
                    r.result_kind = KIND_ROW;
                    r.row_index   = RowW'(i);
                    r.scaler_a    = scaler_at(i);
                    r.scaler_b    = scaler_at(i + 8);
                    r.scaler_c    = scaler_at(i + 16);
                    r.scaler_d    = scaler_at(i + 24);
                    pending_results.push_back(r);
                end
            end
            r = '0;
            r.result_kind  = KIND_SUM;
            r.trigger_bits = trig_accum;
            r.final_result = 1'b1;
            pending_results.push_back(r);
            parse_phase = PH_AWAIT_FIRST;
            chans_left  = '0;
            trig_accum  = '0;
            cal_event   = 1'b0;
        end
    endtask

    // Offer one word after a random gap; expectations are queued on acceptance.
    // Entered and left at a falling edge; valid stays high if the next word has no gap.
    task automatic push_word(input logic [31:0] w, input logic last,
                             input logic typed, input logic [8:0] sum_bits);
        int   gap;
        int   depth_before;
        res_t r;
        gap = send_burst ? 0 : $urandom_range(0, MaxGap);
        if (gap > 0)
        begin
            word_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        word_if.valid     <= 1'b1;
        word_if.data_word <= w;
        word_if.last_word <= last;
        do
            @(posedge clk);
        while (!word_if.ready);
        depth_before = pending_results.size();
        unpack_word(w, last);
        if (typed)
        begin
            // hand-written summary replaces the computed one
            while (pending_results.size() > depth_before)
                void'(pending_results.pop_back());
            r = '0;
            r.result_kind  = KIND_SUM;
            r.trigger_bits = sum_bits;
            r.final_result = 1'b1;
            pending_results.push_back(r);
        end
        @(negedge clk);
    endtask

    // Drop valid and wait at falling edges until every expected word has come back
    task automatic idle_until_drained();
        word_if.valid <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // APB write: setup then access; returns with psel already low, so writes never abut
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CfgAddrW'({idx, 2'b00});
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_TRIG_CRATE: cfg_crate = value[7:0];
            REG_TRIG_SLOT:  cfg_slot  = value[4:0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // Random subevent: mostly well-formed calibration or data, some raw noise
    task automatic build_frame();
        int          kind;
        int          n;
        int          blocks;
        int          count;
        int          chans;
        logic [31:0] w;
        frame_words.delete();
        kind = $urandom_range(0, 19);
        if (kind < 8)
        begin
            w = $urandom;
            w[11:8] = CalTypeNibble;
            frame_words.push_back(w);
            if ($urandom_range(0, 9) < 7)
                frame_words.push_back(CalHeaderWord);
            // now and then enough scalers to overflow the store
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 35) : $urandom_range(0, 10);
            repeat (n)
            begin
                w = $urandom;
                if ($urandom_range(0, 6) != 0)
                    w[31:24] = '0;
                frame_words.push_back(w);
            end
            if ($urandom_range(0, 4) != 0)
            begin
                frame_words.push_back({TrailerMark, 8'($urandom)});
                repeat ($urandom_range(0, 2))
                    frame_words.push_back($urandom);
            end
        end
        else if (kind < 17)
        begin
            w = $urandom;
            if (w[11:8] == CalTypeNibble)
                w[8] = ~w[8];
            frame_words.push_back(w);
            blocks = $urandom_range(0, 3);
            for (int b = 0; b < blocks; b++)
            begin
                case ($urandom_range(0, 6))
                    0:       count = 0;
                    1:       count = $urandom_range(0, 255);
                    default: count = $urandom_range(1, 4);
                endcase
                w = $urandom;
                if ($urandom_range(0, 1))
                    w[31:27] = cfg_slot;
                if ($urandom_range(0, 1))
                    w[23:16] = cfg_crate;
                w[15:8] = count[7:0];
                frame_words.push_back(w);
                chans = (count > 6) ? $urandom_range(0, 6) : count;
                repeat (chans)
                begin
                    w = $urandom;
                    if ($urandom_range(0, 1))
                        w[20:19] = TrigChanHigh;
                    if ($urandom_range(0, 9) == 0)
                        w[11:0] = AdcOverrange;
                    frame_words.push_back(w);
                end
                if (chans < count)
                    break;   // subevent ends inside the channel block
            end
            if ($urandom_range(0, 9) < 6)
            begin
                frame_words.push_back('0);
                repeat ($urandom_range(0, 2))
                    frame_words.push_back($urandom);
            end
        end
        else
        begin
            repeat ($urandom_range(1, 3))
                frame_words.push_back($urandom);
        end
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Compare one accepted result word with the oldest expectation
    task automatic check_result();
        res_t want;
        if (pending_results.size() == 0)
        begin
            $error("result word with nothing expected, kind %0d", res_if.result_kind);
            fail_count++;
        end
        else
        begin
            want = pending_results.pop_front();
            check_field("result_kind",  want.result_kind,  res_if.result_kind);
            check_field("hit_crate",    want.hit_crate,    res_if.hit_crate);
            check_field("hit_slot",     want.hit_slot,     res_if.hit_slot);
            check_field("hit_channel",  want.hit_channel,  res_if.hit_channel);
            check_field("hit_value",    want.hit_value,    res_if.hit_value);
            check_field("row_index",    want.row_index,    res_if.row_index);
            check_field("scaler_a",     want.scaler_a,     res_if.scaler_a);
            check_field("scaler_b",     want.scaler_b,     res_if.scaler_b);
            check_field("scaler_c",     want.scaler_c,     res_if.scaler_c);
            check_field("scaler_d",     want.scaler_d,     res_if.scaler_d);
            check_field("trigger_bits", want.trigger_bits, res_if.trigger_bits);
            check_field("final_result", want.final_result, res_if.final_result);
        end
    endtask

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result sink: random ready gaps, bursts with none, and one long stall that
    // backs the block up until it refuses input words.
    initial
    begin
        int gap;
        res_if.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            gap = take_burst ? 0 : $urandom_range(0, MaxGap);
            if (results_taken == LongHoldAfter)
                gap = LongHoldCycles;
            if (gap > 0)
            begin
                res_if.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            res_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_if.valid);
            check_result();
            results_taken++;
            if ($urandom_range(0, 19) == 0)
                take_burst = !take_burst;
            @(negedge clk);
        end
    end

    // Word source: directed table, then random subevents under several register settings
    initial
    begin
        logic [7:0] crate_plan [PhaseCount];
        logic [4:0] slot_plan [PhaseCount];
        int         sent;
        int         frames;

        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        word_if.valid     = 1'b0;
        word_if.data_word = '0;
        word_if.last_word = 1'b0;

        cfg_crate   = TrigCrateReset;
        cfg_slot    = TrigSlotReset;
        parse_phase = PH_AWAIT_FIRST;
        chans_left  = '0;
        cur_crate   = '0;
        cur_slot    = '0;
        scaler_fill = '0;
        trig_accum  = '0;
        cal_event   = 1'b0;
        clear_scaler_mem();

        // extremes, a random setting, then back to the reset values
        crate_plan = '{8'd0, 8'd255, 8'd0, TrigCrateReset};
        slot_plan  = '{5'd0, 5'd31, 5'd0, TrigSlotReset};
        crate_plan[2] = 8'($urandom);
        slot_plan[2]  = 5'($urandom);

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (DirectedRows[i])
            push_word(DirectedRows[i].word, DirectedRows[i].last,
                      DirectedRows[i].typed, DirectedRows[i].sum_bits);

        for (int ph = 0; ph < PhaseCount; ph++)
        begin
            // registers change only with the block drained and quiet
            idle_until_drained();
            repeat (SettleCycles) @(negedge clk);
            write_reg(REG_TRIG_CRATE, 32'(crate_plan[ph]));
            write_reg(REG_TRIG_SLOT, 32'(slot_plan[ph]));
            sent   = 0;
            frames = 0;
            while (sent < PhaseWords)
            begin
                build_frame();
                send_burst = ($urandom_range(0, 3) == 0);
                foreach (frame_words[i])
                    push_word(frame_words[i], i == frame_words.size() - 1, 1'b0, '0);
                sent += frame_words.size();
                frames++;
                // source pause: let the result side empty out completely
                if (ph == 1 && frames == 3)
                    idle_until_drained();
            end
        end

        idle_until_drained();
        repeat (SettleCycles) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### sim.f
hw/rtl/tdcsu_pkg.sv
hw/rtl/tdcsu_if.sv
hw/rtl/tdcsu_ram.sv
hw/rtl/tdcsu_queue.sv
hw/rtl/tdcsu_front.sv
hw/rtl/tdcsu_back.sv
hw/rtl/tdc_scaler_subevent_unpacker.sv
dv/tb_tdc_scaler_subevent_unpacker.sv
